FILE: rtl/core/cbsh_pkg.sv
package cbsh_pkg;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_EXT  = 2'd1,
      PH_PAY  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEAD    = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_RESERVED = 2'd1,
      ERR_EOD      = 2'd2
   } err_type;

   localparam logic [2:0] MAJOR_UINT  = 3'd0;
   localparam logic [2:0] MAJOR_NINT  = 3'd1;
   localparam logic [2:0] MAJOR_BSTR  = 3'd2;

   localparam logic [4:0] INFO_DIRECT_MAX = 5'd23;
   localparam logic [4:0] INFO_EXT_1      = 5'd24;
   localparam logic [4:0] INFO_EXT_8      = 5'd27;
   localparam logic [4:0] INFO_RSVD_MIN   = 5'd28;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  ext_bytes_left;
      logic [63:0] value_accum;
      logic [2:0]  held_major;
      logic [63:0] payload_left;
   } state_type;

   localparam state_type ST_IDLE = '{
      phase:          PH_IDLE,
      ext_bytes_left: 4'd0,
      value_accum:    64'd0,
      held_major:     3'd0,
      payload_left:   64'd0
   };

   typedef struct packed {
      kind_type           item_kind;
      logic [2:0]         head_major;
      logic [63:0]        head_value;
      logic signed [63:0] signed_view;
      logic               int_overflow;
      logic [7:0]         payload_byte;
      logic               payload_last;
      err_type            error_code;
   } result_type;

endpackage

FILE: rtl/core/cbsh_if.sv
interface cbsh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       buffer_end;

   modport source (output valid, output in_byte, output buffer_end, input ready);
   modport sink   (input valid, input in_byte, input buffer_end, output ready);
endinterface

interface cbsh_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         item_kind;
   logic [2:0]         head_major;
   logic [63:0]        head_value;
   logic signed [63:0] signed_view;
   logic               int_overflow;
   logic [7:0]         payload_byte;
   logic               payload_last;
   logic [1:0]         error_code;

   modport source (output valid, output item_kind, output head_major, output head_value,
                   output signed_view, output int_overflow, output payload_byte,
                   output payload_last, output error_code, input ready);
   modport sink   (input valid, input item_kind, input head_major, input head_value,
                   input signed_view, input int_overflow, input payload_byte,
                   input payload_last, input error_code, output ready);
endinterface

FILE: rtl/core/cbsh_step.sv
module cbsh_step (
   input  cbsh_pkg::state_type  cur_state,
   input  logic [7:0]           in_byte,
   input  logic                 buffer_end,
   output cbsh_pkg::state_type  nxt_state,
   output logic                 emit,
   output cbsh_pkg::result_type result
);

   logic [2:0]  major;
   logic [4:0]  info;
   logic [63:0] acc_shift;
   logic [3:0]  ext_left_dec;
   logic        fin_do;
   logic [2:0]  fin_major;
   logic [63:0] fin_val;

   assign major        = in_byte[7:5];
   assign info         = in_byte[4:0];
   assign acc_shift    = {cur_state.value_accum[55:0], in_byte};
   assign ext_left_dec = cur_state.ext_bytes_left - 4'd1;

   always_comb begin
      nxt_state = cur_state;
      emit      = 1'b0;
      result    = '0;
      fin_do    = 1'b0;
      fin_major = 3'd0;
      fin_val   = 64'd0;

      case (cur_state.phase)
         cbsh_pkg::PH_EXT: begin
            if (ext_left_dec == 4'd0) begin
               fin_do    = 1'b1;
               fin_major = cur_state.held_major;
               fin_val   = acc_shift;
            end else if (buffer_end) begin
               nxt_state         = cbsh_pkg::ST_IDLE;
               emit              = 1'b1;
               result.item_kind  = cbsh_pkg::KIND_ERROR;
               result.error_code = cbsh_pkg::ERR_EOD;
            end else begin
               nxt_state.value_accum    = acc_shift;
               nxt_state.ext_bytes_left = ext_left_dec;
            end
         end
         cbsh_pkg::PH_PAY: begin
            emit = 1'b1;
            if (cur_state.payload_left > 64'd1 && buffer_end) begin
               nxt_state         = cbsh_pkg::ST_IDLE;
               result.item_kind  = cbsh_pkg::KIND_ERROR;
               result.error_code = cbsh_pkg::ERR_EOD;
            end else begin
               result.item_kind    = cbsh_pkg::KIND_PAYLOAD;
               result.payload_byte = in_byte;
               if (cur_state.payload_left <= 64'd1) begin
                  result.payload_last = 1'b1;
                  nxt_state           = cbsh_pkg::ST_IDLE;
               end else begin
                  nxt_state.payload_left = cur_state.payload_left - 64'd1;
               end
            end
         end
         default: begin
            // initial byte; the unused phase code lands here too
            nxt_state = cbsh_pkg::ST_IDLE;
            if (info inside {[5'd0:cbsh_pkg::INFO_DIRECT_MAX]}) begin
               fin_do    = 1'b1;
               fin_major = major;
               fin_val   = {59'd0, info};
            end else if (info inside {[cbsh_pkg::INFO_RSVD_MIN:5'd31]}) begin
               emit              = 1'b1;
               result.item_kind  = cbsh_pkg::KIND_ERROR;
               result.error_code = cbsh_pkg::ERR_RESERVED;
            end else if (buffer_end) begin
               emit              = 1'b1;
               result.item_kind  = cbsh_pkg::KIND_ERROR;
               result.error_code = cbsh_pkg::ERR_EOD;
            end else if (info inside {[cbsh_pkg::INFO_EXT_1:cbsh_pkg::INFO_EXT_8]}) begin
               nxt_state.phase          = cbsh_pkg::PH_EXT;
               nxt_state.held_major     = major;
               // 1, 2, 4 or 8 extension bytes
               nxt_state.ext_bytes_left = 4'b0001 << info[1:0];
            end
         end
      endcase

      if (fin_do) begin
         nxt_state = cbsh_pkg::ST_IDLE;
         emit      = 1'b1;
         if (fin_major == cbsh_pkg::MAJOR_BSTR && fin_val != 64'd0 && buffer_end) begin
            result.item_kind  = cbsh_pkg::KIND_ERROR;
            result.error_code = cbsh_pkg::ERR_EOD;
         end else begin
            if (fin_major == cbsh_pkg::MAJOR_BSTR && fin_val != 64'd0) begin
               nxt_state.phase        = cbsh_pkg::PH_PAY;
               nxt_state.payload_left = fin_val;
            end
            result.item_kind  = cbsh_pkg::KIND_HEAD;
            result.head_major = fin_major;
            result.head_value = fin_val;
            if (fin_major == cbsh_pkg::MAJOR_UINT || fin_major == cbsh_pkg::MAJOR_NINT) begin
               if (fin_val[63]) begin
                  result.int_overflow = 1'b1;
               end else if (fin_major == cbsh_pkg::MAJOR_UINT) begin
                  result.signed_view = fin_val;
               end else begin
                  // -1 - value
                  result.signed_view = ~fin_val;
               end
            end
         end
      end
   end

endmodule

FILE: rtl/core/cbor_stream_head_parser_unit.sv
// channel   dir  payload                                         accepted when
// req_bus   in   in_byte, buffer_end                             valid && ready
// rsp_bus   out  item_kind, head_major, head_value, signed_view, valid && ready
//                int_overflow, payload_byte, payload_last,
//                error_code
//
// One byte per clock while req_bus.ready is high. Each result is registered
// when its byte is taken, or goes to skid while the result register is held.
// Synchronous active-high reset returns the parser to awaiting an initial byte.
// A two-entry output buffer (result register plus skid) keeps req_bus.ready
// high through an rsp_bus stall; ready drops only when both fill.
module cbor_stream_head_parser_unit (
   input logic        clock,
   input logic        reset,
   cbsh_req_if.sink   req_bus,
   cbsh_rsp_if.source rsp_bus
);

   cbsh_pkg::state_type  state_ff;
   cbsh_pkg::state_type  state_in;
   logic                 step_emit;
   cbsh_pkg::result_type step_result;

   logic                 out_valid_ff;
   cbsh_pkg::result_type out_ff;
   logic                 skid_valid_ff;
   cbsh_pkg::result_type skid_ff;

   logic                 req_take;
   logic                 rsp_take;
   logic                 new_result;

   cbsh_step u_step (
      .cur_state  (state_ff),
      .in_byte    (req_bus.in_byte),
      .buffer_end (req_bus.buffer_end),
      .nxt_state  (state_in),
      .emit       (step_emit),
      .result     (step_result)
   );

   assign req_bus.ready = !skid_valid_ff;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign rsp_take      = rsp_bus.valid && rsp_bus.ready;
   assign new_result    = req_take && step_emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cbsh_pkg::ST_IDLE;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            state_ff <= state_in;
         end
         if (!out_valid_ff || rsp_take) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else if (new_result) begin
               out_ff       <= step_result;
               out_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b0;
            end
         end else if (new_result) begin
            // result register still held downstream: park in skid
            skid_ff       <= step_result;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.item_kind    = out_ff.item_kind;
   assign rsp_bus.head_major   = out_ff.head_major;
   assign rsp_bus.head_value   = out_ff.head_value;
   assign rsp_bus.signed_view  = out_ff.signed_view;
   assign rsp_bus.int_overflow = out_ff.int_overflow;
   assign rsp_bus.payload_byte = out_ff.payload_byte;
   assign rsp_bus.payload_last = out_ff.payload_last;
   assign rsp_bus.error_code   = out_ff.error_code;

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BYTE_TARGET = 1550;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 10;

   // Tracks the parser state and holds the results still owed by the block.
   class head_scoreboard;
      cbsh_pkg::phase_type  phase;
      logic [3:0]           ext_left;
      logic [63:0]          accum;
      logic [2:0]           held_major;
      logic [63:0]          pay_left;
      cbsh_pkg::result_type pending_items[$];
      int                   fail_count;

      function new();
         go_idle();
         fail_count = 0;
      endfunction

      function void go_idle();
         phase      = cbsh_pkg::PH_IDLE;
         ext_left   = 4'd0;
         accum      = 64'd0;
         held_major = 3'd0;
         pay_left   = 64'd0;
      endfunction

      function void queue_result(cbsh_pkg::result_type r);
         pending_items.insert(pending_items.size(), r);
      endfunction

      function void push_error(cbsh_pkg::err_type code);
         cbsh_pkg::result_type r;
         r            = '0;
         r.item_kind  = cbsh_pkg::KIND_ERROR;
         r.error_code = code;
         queue_result(r);
      endfunction

      function void finish_head(logic [2:0] major, logic [63:0] val, logic last);
         cbsh_pkg::result_type r;
         go_idle();
         if (major == cbsh_pkg::MAJOR_BSTR && val != 64'd0 && last) begin
            push_error(cbsh_pkg::ERR_EOD);
         end else begin
            if (major == cbsh_pkg::MAJOR_BSTR && val != 64'd0) begin
               phase    = cbsh_pkg::PH_PAY;
               pay_left = val;
            end
            r            = '0;
            r.item_kind  = cbsh_pkg::KIND_HEAD;
            r.head_major = major;
            r.head_value = val;
            if (major == cbsh_pkg::MAJOR_UINT || major == cbsh_pkg::MAJOR_NINT) begin
               if (val > 64'h7fff_ffff_ffff_ffff) begin
                  r.int_overflow = 1'b1;
               end else begin
                  r.signed_view = (major == cbsh_pkg::MAJOR_UINT) ? val : ~val;
               end
            end
            queue_result(r);
         end
      endfunction

      // Called for every accepted input transaction.
      function void note_byte(logic [7:0] b, logic last);
         cbsh_pkg::result_type r;
         logic [2:0] major;
         logic [4:0] info;
         if (phase == cbsh_pkg::PH_EXT) begin
            accum    = {accum[55:0], b};
            ext_left = ext_left - 4'd1;
            if (ext_left == 4'd0) begin
               finish_head(held_major, accum, last);
            end else if (last) begin
               go_idle();
               push_error(cbsh_pkg::ERR_EOD);
            end
         end else if (phase == cbsh_pkg::PH_PAY) begin
            if (pay_left > 64'd1 && last) begin
               go_idle();
               push_error(cbsh_pkg::ERR_EOD);
            end else begin
               r              = '0;
               r.item_kind    = cbsh_pkg::KIND_PAYLOAD;
               r.payload_byte = b;
               if (pay_left <= 64'd1) begin
                  r.payload_last = 1'b1;
                  go_idle();
               end else begin
                  pay_left = pay_left - 64'd1;
               end
               queue_result(r);
            end
         end else begin
            major = b[7:5];
            info  = b[4:0];
            go_idle();
            if (info <= cbsh_pkg::INFO_DIRECT_MAX) begin
               finish_head(major, {59'd0, info}, last);
            end else if (info >= cbsh_pkg::INFO_RSVD_MIN) begin
               push_error(cbsh_pkg::ERR_RESERVED);
            end else if (last) begin
               push_error(cbsh_pkg::ERR_EOD);
            end else begin
               phase      = cbsh_pkg::PH_EXT;
               held_major = major;
               accum      = 64'd0;
               ext_left   = 4'd1 << (info - cbsh_pkg::INFO_EXT_1);
            end
         end
      endfunction

      function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
         if (exp_v !== act_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         end
      endfunction

      // Called for every accepted result transaction.
      function void check_item(cbsh_pkg::result_type got);
         cbsh_pkg::result_type want;
         if (pending_items.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result, expected none, actual kind %0d",
                     $time, got.item_kind);
         end else begin
            want = pending_items.pop_front();
            compare_field("item_kind", 64'(want.item_kind), 64'(got.item_kind));
            compare_field("head_major", 64'(want.head_major), 64'(got.head_major));
            compare_field("head_value", want.head_value, got.head_value);
            compare_field("signed_view", want.signed_view, got.signed_view);
            compare_field("int_overflow", 64'(want.int_overflow), 64'(got.int_overflow));
            compare_field("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
            compare_field("payload_last", 64'(want.payload_last), 64'(got.payload_last));
            compare_field("error_code", 64'(want.error_code), 64'(got.error_code));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   bytes_sent = 0;
   bit   no_idle = 1'b0;

   head_scoreboard sb = new();

   cbsh_req_if req_if ();
   cbsh_rsp_if rsp_if ();

   cbor_stream_head_parser_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   always #5ns clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout, %0d results outstanding", $time, sb.pending_items.size());
      $display("[cbor_stream_head_parser_unit] ERROR");
      $finish;
   end

   always @(posedge clock) begin
      cbsh_pkg::result_type got;
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_byte(req_if.in_byte, req_if.buffer_end);
         if (rsp_if.valid && rsp_if.ready) begin
            got.item_kind    = cbsh_pkg::kind_type'(rsp_if.item_kind);
            got.head_major   = rsp_if.head_major;
            got.head_value   = rsp_if.head_value;
            got.signed_view  = rsp_if.signed_view;
            got.int_overflow = rsp_if.int_overflow;
            got.payload_byte = rsp_if.payload_byte;
            got.payload_last = rsp_if.payload_last;
            got.error_code   = cbsh_pkg::err_type'(rsp_if.error_code);
            sb.check_item(got);
         end
      end
   end

   // Result side: random stall before each transaction.
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.in_byte    <= b;
      req_if.buffer_end <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Always advances at least one edge so valid never gets two updates in one step.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.pending_items.size() != 0);
   endtask

   // width_code -1: argument in the initial byte, else 1 << width_code extension bytes
   task automatic send_head(input logic [2:0] major, input logic [63:0] value,
                            input int width_code, input logic end_last);
      logic [4:0] info;
      int n;
      if (width_code < 0) begin
         send_byte({major, value[4:0]}, end_last);
      end else begin
         n    = 1 << width_code;
         info = cbsh_pkg::INFO_EXT_1 + 5'(width_code);
         send_byte({major, info}, 1'b0);
         for (int i = n - 1; i >= 0; i--)
            send_byte(value[i*8 +: 8], end_last && i == 0);
      end
   endtask

   function automatic logic [63:0] pick_value(int width_code);
      logic [63:0] v;
      int bits;
      if (width_code < 0) begin
         v = 64'($urandom_range(0, 23));
      end else begin
         bits = 8 << width_code;
         case ($urandom_range(0, 5))
            0:       v = 64'd0;
            1:       v = '1;
            2:       v = 64'h8000_0000_0000_0000;
            3:       v = 64'h7fff_ffff_ffff_ffff;
            default: v = {$urandom, $urandom};
         endcase
         if (bits < 64)
            v = v & ((64'd1 << bits) - 64'd1);
      end
      return v;
   endfunction

   task automatic send_data_item();
      logic [2:0]  major;
      logic [63:0] value;
      logic        end_last;
      int          width_code;
      int          len;
      major    = 3'($urandom_range(0, 7));
      end_last = ($urandom_range(0, 3) == 0);
      if (major == cbsh_pkg::MAJOR_BSTR) begin
         len        = $urandom_range(0, 12);
         width_code = int'($urandom_range(0, 4)) - 1;
         send_head(major, 64'(len), width_code, end_last && len == 0);
         for (int i = 0; i < len; i++)
            send_byte(8'($urandom), end_last && i == len - 1);
      end else begin
         width_code = int'($urandom_range(0, 4)) - 1;
         value      = pick_value(width_code);
         send_head(major, value, width_code, end_last);
      end
   endtask

   // buffer ends on the initial byte or inside the extension bytes
   task automatic send_cut_head();
      int width_code;
      int cut;
      width_code = $urandom_range(0, 3);
      cut        = $urandom_range(0, (1 << width_code) - 1);
      send_byte({3'($urandom_range(0, 7)), cbsh_pkg::INFO_EXT_1 + 5'(width_code)}, cut == 0);
      for (int i = 1; i <= cut; i++)
         send_byte(8'($urandom), i == cut);
   endtask

   // buffer ends on the byte-string head or before its last content byte
   task automatic send_cut_string();
      logic [63:0] len;
      int width_code;
      int m;
      if ($urandom_range(0, 1) == 0) begin
         len        = 64'($urandom_range(2, 12));
         width_code = int'($urandom_range(0, 4)) - 1;
      end else begin
         len        = {$urandom, $urandom} | 64'h100;
         width_code = 3;
      end
      if ($urandom_range(0, 2) == 0) begin
         send_head(cbsh_pkg::MAJOR_BSTR, len, width_code, 1'b1);
      end else begin
         send_head(cbsh_pkg::MAJOR_BSTR, len, width_code, 1'b0);
         m = $urandom_range(1, (len - 64'd1 > 64'd6) ? 6 : int'(len) - 1);
         for (int i = 0; i < m; i++)
            send_byte(8'($urandom), i == m - 1);
      end
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
         send_byte(8'($urandom), i == n - 1);
   endtask

   logic [8:0] directed_bytes[] = '{
      9'h000,                                              // uint 0
      9'h037,                                              // nint 23
      9'h03b, 9'h080, 9'h000, 9'h000, 9'h000,              // nint 2^63, overflow
      9'h000, 9'h000, 9'h000, 9'h000,
      9'h019, 9'h001, 9'h002,                              // two-byte argument
      9'h01c, 9'h0ff,                                      // reserved / indefinite info
      9'h042, 9'h0aa, 9'h055,                              // byte string of two
      9'h040,                                              // empty byte string
      9'h11a,                                              // head cut at initial byte
      9'h142,                                              // string cut at its head
      9'h043, 9'h011, 9'h122                               // string cut in content
   };

   initial begin
      int sel;
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.in_byte    <= 8'd0;
      req_if.buffer_end <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_bytes[i])
         send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
      drain_results();

      while (bytes_sent < BYTE_TARGET) begin
         if ($urandom_range(0, 9) == 0)
            no_idle = !no_idle;
         if ($urandom_range(0, 79) == 0)
            drain_results();
         sel = $urandom_range(0, 99);
         if (sel < 60)
            send_data_item();
         else if (sel < 72)
            send_cut_head();
         else if (sel < 82)
            send_cut_string();
         else if (sel < 90)
            send_byte({3'($urandom_range(0, 7)), 5'($urandom_range(28, 31))},
                      $urandom_range(0, 3) == 0);
         else
            send_noise();
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending_items.size() != 0)
         $display("%0t: %0d expected results never arrived", $time, sb.pending_items.size());
      if (sb.fail_count == 0 && sb.pending_items.size() == 0) begin
         $display("[cbor_stream_head_parser_unit] OK");
      end else begin
         $display("[cbor_stream_head_parser_unit] ERROR");
      end
      $finish;
   end

endmodule
